>>> sv/ip_mac_binding_tracker_unit_macros.svh
// Assertion macros shared by the binding tracker checker.
`ifndef IP_MAC_BINDING_TRACKER_UNIT_MACROS_SVH
`define IP_MAC_BINDING_TRACKER_UNIT_MACROS_SVH

// Same-cycle implication on i_clk, disabled while i_rst_n is asserted.
`define MBT_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on i_clk, disabled while i_rst_n is asserted.
`define MBT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/mbt_pkg.sv
// Shared types and constants of the IP-to-MAC binding tracker.
`default_nettype none

package mbt_pkg;

    // Default number of table entries.
    localparam int TABLE_DEPTH_DEF = 8;

    // Payload field widths.
    localparam int FUNC_W = 2;
    localparam int IP_W   = 32;
    localparam int MAC_W  = 48;

    typedef logic [FUNC_W-1:0] t_func;

    // Operation codes.
    localparam t_func FUNC_MARK  = 2'd0;
    localparam t_func FUNC_QUERY = 2'd1;
    localparam t_func FUNC_CLEAR = 2'd2;

    // One operation as it sits in the input register.
    typedef struct packed {
        t_func            func;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } t_req;

    // Lookup result handed to the result register.
    typedef struct packed {
        logic             hit;
        logic [MAC_W-1:0] mac;
    } t_rsp;

endpackage

`default_nettype wire

>>> sv/mbt_table.sv
// Fully associative binding table with parallel lookup and round-robin insertion.
`default_nettype none

module mbt_table #(
    parameter int TABLE_DEPTH = mbt_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_commit,
    input  mbt_pkg::t_req     i_req,
    output mbt_pkg::t_rsp     o_rsp
);

    localparam int PTR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(TABLE_DEPTH - 1);

    logic [TABLE_DEPTH-1:0]     r_valid;
    logic [mbt_pkg::IP_W-1:0]   r_ip  [TABLE_DEPTH];
    logic [mbt_pkg::MAC_W-1:0]  r_mac [TABLE_DEPTH];
    logic [PTR_W-1:0]           r_ptr;
    logic [PTR_W-1:0]           n_ptr;

    logic [TABLE_DEPTH-1:0]     match;
    logic                       match_any;
    logic [PTR_W-1:0]           match_idx;
    logic                       ip_nz;
    logic                       do_insert;
    logic                       do_rewrite;
    logic                       do_clear;

    // Compare the request against every entry at once.
    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            match[i] = r_valid[i] && (r_ip[i] == i_req.ip);
        end
    end

    // The lowest-numbered matching entry wins.
    always_comb begin
        match_any = 1'b0;
        match_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (match[i]) begin
                match_any = 1'b1;
                match_idx = PTR_W'(i);
            end
        end
    end

    assign ip_nz = (i_req.ip != '0);

    // Result reflects the table before this operation's update.
    assign o_rsp.hit = ip_nz && match_any;
    assign o_rsp.mac = o_rsp.hit ? r_mac[match_idx] : '0;

    // Decode which update this operation makes.
    always_comb begin
        do_insert  = 1'b0;
        do_rewrite = 1'b0;
        do_clear   = 1'b0;
        if (i_commit && ip_nz) begin
            unique case (i_req.func)
                mbt_pkg::FUNC_MARK: begin
                    do_rewrite = match_any;
                    do_insert  = !match_any;
                end
                mbt_pkg::FUNC_CLEAR: begin
                    do_clear = match_any;
                end
                mbt_pkg::FUNC_QUERY: begin
                    // A query leaves the table unchanged.
                end
                default: begin
                    // The spare code behaves as a query.
                end
            endcase
        end
    end

    // Round-robin pointer wraps at the table depth.
    assign n_ptr = (r_ptr == PTR_LAST) ? '0 : r_ptr + PTR_W'(1);

    // Valid bits and insertion pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ptr   <= '0;
        end else begin
            if (do_insert) begin
                r_valid[r_ptr] <= 1'b1;
                r_ptr          <= n_ptr;
            end else if (do_clear) begin
                r_valid[match_idx] <= 1'b0;
            end
        end
    end

    // Entry payload; only read behind a set valid bit.
    always_ff @(posedge i_clk) begin
        if (do_insert) begin
            r_ip[r_ptr]  <= i_req.ip;
            r_mac[r_ptr] <= i_req.mac;
        end else if (do_rewrite) begin
            r_mac[match_idx] <= i_req.mac;
        end
    end

endmodule

`default_nettype wire

>>> sv/ip_mac_binding_tracker_unit.sv
// Top level of the IP-to-MAC binding tracker: input register, table and result register.
// The block accepts one transaction per clock cycle while the output side is not stalled and
// returns exactly one result per transaction, passing through the input register and then the
// result register. The lookup and the table update happen between the input register and
// the result register, so each transaction sees every update made by the one before it.
// The table lives in flip-flops and is empty right after reset; there is no clearing pass.
// The result register holds while the consumer stalls, and the input register keeps
// accepting while it is empty or its content can move on in the same cycle.
`default_nettype none

module ip_mac_binding_tracker_unit #(
    parameter int TABLE_DEPTH = mbt_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [mbt_pkg::FUNC_W-1:0] i_func,
    input  wire logic [mbt_pkg::IP_W-1:0]   i_client_ip,
    input  wire logic [mbt_pkg::MAC_W-1:0]  i_client_mac,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic                            o_hit,
    output logic [mbt_pkg::MAC_W-1:0]       o_matched_mac
);

    logic           r_in_vld;
    mbt_pkg::t_req  r_in;
    logic           r_out_vld;
    mbt_pkg::t_rsp  r_out;
    mbt_pkg::t_rsp  rsp;
    logic           advance;

    // The held transaction moves on when the result register is free or being drained.
    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in.func <= i_func;
            r_in.ip   <= i_client_ip;
            r_in.mac  <= i_client_mac;
        end
    end

    // Lookup and update of the binding table.
    mbt_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (advance),
        .i_req    (r_in),
        .o_rsp    (rsp)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= rsp;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_hit         = r_out.hit;
    assign o_matched_mac = r_out.mac;

endmodule

`default_nettype wire

>>> sv/mbt_checker.sv
// Port-level checker of the binding tracker and its bind to the top level.
`default_nettype none
`include "ip_mac_binding_tracker_unit_macros.svh"

module mbt_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       o_in_ready,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_ready,
    input wire logic                       o_hit,
    input wire logic [mbt_pkg::MAC_W-1:0]  o_matched_mac
);

    logic                      out_stall;
    logic                      out_take;
    logic                      out_miss;
    logic                      in_idle;
    logic [mbt_pkg::MAC_W:0]   out_word;

    // Handshake conditions used by the properties below.
    assign out_stall = o_out_valid && !i_out_ready;
    assign out_take  = o_out_valid && i_out_ready;
    assign out_miss  = o_out_valid && !o_hit;
    assign in_idle   = o_in_ready && !i_in_valid;
    assign out_word  = {o_hit, o_matched_mac};

    // A stalled result keeps its payload.
    `MBT_ASSERT_NEXT(a_out_hold, out_stall, o_out_valid && $stable(out_word), "held result changed")

    // A miss never carries a MAC.
    `MBT_ASSERT_IMPLY(a_miss_zero_mac, out_miss, o_matched_mac == '0, "miss with nonzero MAC")

    // With the result register empty, the input side must be able to take a transaction.
    `MBT_ASSERT_IMPLY(a_ready_empty, !o_out_valid, o_in_ready, "input stalled while empty")

    // A drained result with the input idle leaves the input side ready in the next cycle.
    `MBT_ASSERT_NEXT(a_drain, out_take && in_idle, o_in_ready, "input stalled after idle")

endmodule

bind ip_mac_binding_tracker_unit mbt_checker u_mbt_checker (.*);

`default_nettype wire
